// ===== rtl/core/gamepad_button_remap_macros.svh =====
// ----------------------------------------------------------------------------
// Gamepad button remap assertion macros
// Shared concurrent assertion wrappers, clocked on aclk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_BUTTON_REMAP_MACROS_SVH
`define GAMEPAD_BUTTON_REMAP_MACROS_SVH

// same-cycle implication
`define GBR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/gbr_pkg.sv =====
// ----------------------------------------------------------------------------
// Gamepad button remap package
// Shared types, register codes, button masks and the target mask table.
// ----------------------------------------------------------------------------
package gbr_pkg;

    localparam int WORD_W = 27;   // mapped button word incl. virtual bits
    localparam int SEL_W  = 5;    // one table index

    // configuration register indices
    localparam logic [2:0] REG_DPAD_SELECT    = 3'd0;
    localparam logic [2:0] REG_FACE_SELECT    = 3'd1;
    localparam logic [2:0] REG_TRIGGER_SELECT = 3'd2;
    localparam logic [2:0] REG_CBUTTON_SELECT = 3'd3;
    localparam logic [2:0] REG_EXIT_COMBO     = 3'd4;
    localparam logic [2:0] REG_AXIS_SOURCE    = 3'd5;
    localparam logic [2:0] REG_INVERT_AXES    = 3'd6;
    localparam logic [2:0] REG_TRIG_THRESHOLD = 3'd7;

    // reset values
    localparam logic [19:0] RST_DPAD_SELECT    = 20'd134209;
    localparam logic [14:0] RST_FACE_SELECT    = 15'd9413;
    localparam logic [14:0] RST_TRIGGER_SELECT = 15'd19057;
    localparam logic [19:0] RST_CBUTTON_SELECT = 20'd540109;
    localparam logic [7:0]  RST_TRIG_THRESHOLD = 8'd48;

    // raw button bit positions
    localparam int BIT_B       = 1;
    localparam int BIT_A       = 2;
    localparam int BIT_START   = 3;
    localparam int BIT_D_UP    = 4;
    localparam int BIT_D_DOWN  = 5;
    localparam int BIT_D_LEFT  = 6;
    localparam int BIT_D_RIGHT = 7;
    localparam int BIT_Y       = 9;
    localparam int BIT_X       = 10;
    localparam int BIT_D2_UP   = 12;
    localparam int BIT_D2_DOWN = 13;
    localparam int BIT_D2_LEFT = 14;
    localparam int BIT_D2_RGHT = 15;
    localparam int BIT_VLTRIG  = 24;
    localparam int BIT_VRTRIG  = 25;
    localparam int BIT_VLTALT  = 26;

    // exit combos
    localparam logic [WORD_W-1:0] COMBO_SAB = 27'h000000E;
    localparam logic [WORD_W-1:0] COMBO_SX  = 27'h0000408;

    // axis constants
    localparam logic [7:0] AXIS_CENTRE  = 8'h80;
    localparam logic [7:0] AXIS_POS_MAG = 8'd80;
    localparam logic [7:0] AXIS_NEG_MAG = 8'hB0;   // -80

    typedef struct packed {
        logic [19:0] dpad_select;
        logic [14:0] face_select;
        logic [14:0] trigger_select;
        logic [19:0] cbutton_select;
        logic        exit_combo;
        logic        axis_source;
        logic [1:0]  invert_axes;
        logic [7:0]  trigger_threshold;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  pad_index;
        logic        pad_present;
        logic [15:0] raw_buttons;
        logic [7:0]  stick_x;
        logic [7:0]  stick_y;
        logic [7:0]  left_trigger;
        logic [7:0]  right_trigger;
    } poll_t;

    typedef struct packed {
        logic [1:0]        source_pad;
        logic              pad_ok;
        logic [13:0]       target_buttons;
        logic [7:0]        x_axis;
        logic [7:0]        y_axis;
        logic              menu_exit;
        logic [WORD_W-1:0] mapped_word;
    } result_t;

    // target mask table; unused indices give an empty mask
    function automatic logic [WORD_W-1:0] mask_of(input logic [SEL_W-1:0] idx);
        logic [WORD_W-1:0] m;
        m = '0;
        case (idx)
            5'd1:    m[BIT_D_UP]    = 1'b1;
            5'd2:    m[BIT_D_LEFT]  = 1'b1;
            5'd3:    m[BIT_D_RIGHT] = 1'b1;
            5'd4:    m[BIT_D_DOWN]  = 1'b1;
            5'd5:    m[BIT_A]       = 1'b1;
            5'd6:    m[BIT_B]       = 1'b1;
            5'd7:    m[BIT_X]       = 1'b1;
            5'd8:    m[BIT_Y]       = 1'b1;
            5'd9:    m[BIT_START]   = 1'b1;
            5'd10:   m[0]           = 1'b1;
            5'd11:   m[8]           = 1'b1;
            5'd12:   m[11]          = 1'b1;
            5'd13:   m[BIT_D2_UP]   = 1'b1;
            5'd14:   m[BIT_D2_LEFT] = 1'b1;
            5'd15:   m[BIT_D2_RGHT] = 1'b1;
            5'd16:   m[BIT_D2_DOWN] = 1'b1;
            5'd17:   m[BIT_VLTRIG]  = 1'b1;
            5'd18:   m[BIT_VRTRIG]  = 1'b1;
            5'd19:   m[BIT_VLTALT]  = 1'b1;
            default: m = '0;
        endcase
        return m;
    endfunction

    // a target is held when its (non-empty) mask is fully set in the word
    function automatic logic held(input logic [WORD_W-1:0] word,
                                  input logic [SEL_W-1:0] idx);
        logic [WORD_W-1:0] m;
        m = mask_of(idx);
        return (m != '0) && ((word & m) == m);
    endfunction

endpackage

// ===== rtl/core/gamepad_button_remap.sv =====
// ----------------------------------------------------------------------------
// Gamepad button remap
// Remaps one pad poll per word into a target controller state.
//
// Usage:
//   s_* channel carries one poll word (pad port, presence, buttons, stick,
//   triggers); m_* channel returns one remapped word for each poll, in order.
//   Both channels use valid/ready. Configuration goes through cfg_we,
//   cfg_addr and cfg_wdata, one register per cycle, written while idle.
//   The poll register loads at acceptance and the result register loads from
//   it once the result slot is free; m_valid shows the result register.
//   Throughput: one word per cycle while m_ready holds, set by the single
//   combinational pass between the two registers.
//   Reset (aresetn low, synchronous) empties both registers and loads the
//   default button assignment and a trigger threshold of 48.
//   When the receiver stalls, the result register holds and the poll
//   register still takes one more word; s_ready drops only once both are
//   full and resumes in the cycle m_ready returns.
// ----------------------------------------------------------------------------
`include "gamepad_button_remap_macros.svh"

module gamepad_button_remap (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [2:0]        cfg_addr,
    input  logic [19:0]       cfg_wdata,
    // poll input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_pad_index,
    input  logic              s_pad_present,
    input  logic [15:0]       s_raw_buttons,
    input  logic [7:0]        s_stick_x,
    input  logic [7:0]        s_stick_y,
    input  logic [7:0]        s_left_trigger,
    input  logic [7:0]        s_right_trigger,
    // remapped output
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_source_pad,
    output logic              m_pad_ok,
    output logic [13:0]       m_target_buttons,
    output logic signed [7:0] m_x_axis,
    output logic signed [7:0] m_y_axis,
    output logic              m_menu_exit,
    output logic [26:0]       m_mapped_word
);
    import gbr_pkg::*;

    cfg_t    cfg;
    poll_t   poll_in;
    poll_t   poll_reg;
    poll_t   poll_next;
    logic    poll_valid_reg;
    logic    poll_valid_next;
    result_t res_comb;
    result_t res_reg;
    result_t res_next;
    logic    res_valid_reg;
    logic    res_valid_next;
    logic    out_free;
    logic    poll_adv;
    logic    s_take;
    logic    both_full;
    logic    absent_zero;
    logic    trig_bits_ok;

    gbr_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gbr_remap u_remap (
        .cfg  (cfg),
        .poll (poll_reg),
        .res  (res_comb)
    );

    assign poll_in = '{pad_index:     s_pad_index,
                       pad_present:   s_pad_present,
                       raw_buttons:   s_raw_buttons,
                       stick_x:       s_stick_x,
                       stick_y:       s_stick_y,
                       left_trigger:  s_left_trigger,
                       right_trigger: s_right_trigger};

    // handshake: result slot frees when empty or taken
    assign out_free = !res_valid_reg || m_ready;
    assign poll_adv = poll_valid_reg && out_free;
    assign s_ready  = !poll_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    // next state of both stages
    always_comb begin
        poll_valid_next = s_ready ? s_valid : poll_valid_reg;
        poll_next       = s_take ? poll_in : poll_reg;
        res_valid_next  = out_free ? poll_valid_reg : res_valid_reg;
        res_next        = poll_adv ? res_comb : res_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poll_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            poll_valid_reg <= poll_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        poll_reg <= poll_next;
        res_reg  <= res_next;
    end

    assign m_valid          = res_valid_reg;
    assign m_source_pad     = res_reg.source_pad;
    assign m_pad_ok         = res_reg.pad_ok;
    assign m_target_buttons = res_reg.target_buttons;
    assign m_x_axis         = res_reg.x_axis;
    assign m_y_axis         = res_reg.y_axis;
    assign m_menu_exit      = res_reg.menu_exit;
    assign m_mapped_word    = res_reg.mapped_word;

    // check terms
    assign both_full    = poll_valid_reg && res_valid_reg;
    assign absent_zero  = (m_source_pad == 2'd0) && (m_target_buttons == 14'd0) &&
                          (m_mapped_word == 27'd0) && !m_menu_exit &&
                          (m_x_axis == 8'sd0) && (m_y_axis == 8'sd0);
    assign trig_bits_ok = !(m_mapped_word[24] && m_mapped_word[26]) &&
                          (m_mapped_word[23:16] == 8'd0);

    // checks
    `GBR_ASSERT_IMPL(a_full_stall, both_full && !m_ready, !s_ready, "word taken while full")
    `GBR_ASSERT_NEXT(a_advance, poll_adv, res_valid_reg, "polled word lost on its way out")
    `GBR_ASSERT_IMPL(a_absent_zero, res_valid_reg && !m_pad_ok, absent_zero, "missing pad not zero")
    `GBR_ASSERT_IMPL(a_trig_bits, res_valid_reg, trig_bits_ok, "bad virtual trigger bits")

endmodule

// ===== rtl/core/gbr_cfg.sv =====
// ----------------------------------------------------------------------------
// Gamepad button remap configuration registers
// Holds the eight settings, written through a simple indexed write port.
// ----------------------------------------------------------------------------
module gbr_cfg (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_addr,
    input  logic [19:0]  cfg_wdata,
    output gbr_pkg::cfg_t cfg
);
    import gbr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_DPAD_SELECT:    cfg_next.dpad_select       = cfg_wdata;
                REG_FACE_SELECT:    cfg_next.face_select       = cfg_wdata[14:0];
                REG_TRIGGER_SELECT: cfg_next.trigger_select    = cfg_wdata[14:0];
                REG_CBUTTON_SELECT: cfg_next.cbutton_select    = cfg_wdata;
                REG_EXIT_COMBO:     cfg_next.exit_combo        = cfg_wdata[0];
                REG_AXIS_SOURCE:    cfg_next.axis_source       = cfg_wdata[0];
                REG_INVERT_AXES:    cfg_next.invert_axes       = cfg_wdata[1:0];
                REG_TRIG_THRESHOLD: cfg_next.trigger_threshold = cfg_wdata[7:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dpad_select       <= RST_DPAD_SELECT;
            cfg_reg.face_select       <= RST_FACE_SELECT;
            cfg_reg.trigger_select    <= RST_TRIGGER_SELECT;
            cfg_reg.cbutton_select    <= RST_CBUTTON_SELECT;
            cfg_reg.exit_combo        <= 1'b0;
            cfg_reg.axis_source       <= 1'b0;
            cfg_reg.invert_axes       <= 2'd0;
            cfg_reg.trigger_threshold <= RST_TRIG_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/gbr_remap.sv =====
// ----------------------------------------------------------------------------
// Gamepad button remap datapath
// Trigger folding, target matching, exit combo and axis generation for one poll.
// ----------------------------------------------------------------------------
module gbr_remap (
    input  gbr_pkg::cfg_t    cfg,
    input  gbr_pkg::poll_t   poll,
    output gbr_pkg::result_t res
);
    import gbr_pkg::*;

    logic              lheld;
    logic              rheld;
    logic [WORD_W-1:0] word;
    logic [13:0]       tgt;
    logic [WORD_W-1:0] combo;
    logic [7:0]        x_raw;
    logic [7:0]        y_raw;
    logic [7:0]        x_fin;
    logic [7:0]        y_fin;

    // trigger folding into the button word
    always_comb begin
        lheld = poll.left_trigger  >= cfg.trigger_threshold;
        rheld = poll.right_trigger >= cfg.trigger_threshold;
        word  = {{(WORD_W-16){1'b0}}, poll.raw_buttons};
        if (lheld && rheld) begin
            // both held: D-pad moves onto the second D-pad
            word[BIT_D2_UP]   = word[BIT_D2_UP]   | poll.raw_buttons[BIT_D_UP];
            word[BIT_D2_DOWN] = word[BIT_D2_DOWN] | poll.raw_buttons[BIT_D_DOWN];
            word[BIT_D2_LEFT] = word[BIT_D2_LEFT] | poll.raw_buttons[BIT_D_LEFT];
            word[BIT_D2_RGHT] = word[BIT_D2_RGHT] | poll.raw_buttons[BIT_D_RIGHT];
            word[BIT_D_RIGHT:BIT_D_UP] = 4'd0;
        end else begin
            if (lheld) begin
                if (poll.raw_buttons[BIT_Y]) begin
                    word[BIT_VLTALT] = 1'b1;
                end else begin
                    word[BIT_VLTRIG] = 1'b1;
                end
            end
            if (rheld) begin
                word[BIT_VRTRIG] = 1'b1;
            end
        end
    end

    // target matching through the select indices
    always_comb begin
        tgt[0]  = held(word, cfg.dpad_select[14:10]);
        tgt[1]  = held(word, cfg.dpad_select[9:5]);
        tgt[2]  = held(word, cfg.dpad_select[19:15]);
        tgt[3]  = held(word, cfg.dpad_select[4:0]);
        tgt[4]  = held(word, cfg.face_select[14:10]);
        tgt[5]  = held(word, cfg.face_select[9:5]);
        tgt[6]  = held(word, cfg.face_select[4:0]);
        tgt[7]  = held(word, cfg.trigger_select[4:0]);
        tgt[8]  = held(word, cfg.trigger_select[14:10]);
        tgt[9]  = held(word, cfg.trigger_select[9:5]);
        tgt[10] = held(word, cfg.cbutton_select[14:10]);
        tgt[11] = held(word, cfg.cbutton_select[9:5]);
        tgt[12] = held(word, cfg.cbutton_select[19:15]);
        tgt[13] = held(word, cfg.cbutton_select[4:0]);
    end

    assign combo = cfg.exit_combo ? COMBO_SX : COMBO_SAB;

    // axes: centred stick or D-pad, then optional negation (wraps -128)
    always_comb begin
        x_raw = 8'd0;
        y_raw = 8'd0;
        if (!cfg.axis_source) begin
            x_raw = poll.stick_x - AXIS_CENTRE;
            y_raw = AXIS_CENTRE - poll.stick_y;
        end else begin
            if (word[BIT_D_RIGHT]) begin
                x_raw = AXIS_POS_MAG;
            end else if (word[BIT_D_LEFT]) begin
                x_raw = AXIS_NEG_MAG;
            end
            if (word[BIT_D_UP]) begin
                y_raw = AXIS_POS_MAG;
            end else if (word[BIT_D_DOWN]) begin
                y_raw = AXIS_NEG_MAG;
            end
        end
        x_fin = cfg.invert_axes[1] ? (8'd0 - x_raw) : x_raw;
        y_fin = cfg.invert_axes[0] ? (8'd0 - y_raw) : y_raw;
    end

    // missing pad gives an all-zero word
    always_comb begin
        res = '0;
        if (poll.pad_present) begin
            res.source_pad     = poll.pad_index;
            res.pad_ok         = 1'b1;
            res.target_buttons = tgt;
            res.x_axis         = x_fin;
            res.y_axis         = y_fin;
            res.menu_exit      = (word & combo) == combo;
            res.mapped_word    = word;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad button remap testbench
// Drives pad polls through the valid/ready input with random gaps, stalls the
// result side at random, and checks each remapped word field by field against
// a behavioural remap under the current register setting, or a pinned word. A
// short table of directed polls comes first, then random polls over several
// register settings, including all-zero and all-one extremes.
// ----------------------------------------------------------------------------
module tb_top;
    import gbr_pkg::*;

    localparam int STALL_LIMIT = 400;      // cycles with no word moving
    localparam int PHASES      = 13;
    localparam int PHASE_POLLS = 150;

    // table index -> button word bit it tests (entry 0 is never used)
    localparam int TARGET_BIT [20] = '{0, 4, 6, 7, 5, 2, 1, 10, 9, 3,
                                       0, 8, 11, 12, 14, 15, 13, 24, 25, 26};

    localparam cfg_t DEFAULT_SETTING = {RST_DPAD_SELECT, RST_FACE_SELECT,
                                        RST_TRIGGER_SELECT, RST_CBUTTON_SELECT,
                                        1'b0, 1'b0, 2'b00, RST_TRIG_THRESHOLD};

    typedef struct {
        poll_t   poll;
        bit      pinned;     // expected word typed in below
        result_t res;
    } probe_row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [2:0]        cfg_addr;
    logic [19:0]       cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    poll_t             s_poll;
    logic              m_valid;
    logic              m_ready;
    logic [1:0]        m_source_pad;
    logic              m_pad_ok;
    logic [13:0]       m_target_buttons;
    logic signed [7:0] m_x_axis;
    logic signed [7:0] m_y_axis;
    logic              m_menu_exit;
    logic [26:0]       m_mapped_word;

    cfg_t       shadow_cfg;
    result_t    pending_maps [$];
    probe_row_t probe_rows [$];
    bit         pinned_on;
    result_t    pinned_res;
    int         mismatches;
    int         idle_cycles;
    int         src_calm;
    int         snk_calm;

    gamepad_button_remap i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pad_index      (s_poll.pad_index),
        .s_pad_present    (s_poll.pad_present),
        .s_raw_buttons    (s_poll.raw_buttons),
        .s_stick_x        (s_poll.stick_x),
        .s_stick_y        (s_poll.stick_y),
        .s_left_trigger   (s_poll.left_trigger),
        .s_right_trigger  (s_poll.right_trigger),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_source_pad     (m_source_pad),
        .m_pad_ok         (m_pad_ok),
        .m_target_buttons (m_target_buttons),
        .m_x_axis         (m_x_axis),
        .m_y_axis         (m_y_axis),
        .m_menu_exit      (m_menu_exit),
        .m_mapped_word    (m_mapped_word)
    );

    // 50 MHz clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------
    // Remap prediction
    // ------------------------------------------------------------------

    // one target slot: is the button its table index names held in the word
    function automatic logic slot_hit(input logic [26:0] w, input logic [19:0] sel,
                                      input int slot);
        logic [4:0] idx;
        idx = sel[5*slot +: 5];
        if (idx == 5'd0 || idx > 5'd19)
            return 1'b0;
        return w[TARGET_BIT[idx]];
    endfunction

    function automatic result_t remap_poll(input poll_t p, input cfg_t c);
        result_t     r;
        logic [26:0] w;
        logic [26:0] combo;
        logic [19:0] face, trig;
        logic        lt_on, rt_on;
        logic [7:0]  x, y;
        r = '0;
        // no pad: everything reads zero, port number too
        if (!p.pad_present)
            return r;
        w     = {11'd0, p.raw_buttons};
        face  = {5'd0, c.face_select};
        trig  = {5'd0, c.trigger_select};
        lt_on = (p.left_trigger >= c.trigger_threshold);
        rt_on = (p.right_trigger >= c.trigger_threshold);
        // both triggers: D-pad slides onto the second D-pad, no virtual bits
        if (lt_on && rt_on) begin
            w[BIT_D2_UP]   = w[BIT_D2_UP]   | w[BIT_D_UP];
            w[BIT_D2_DOWN] = w[BIT_D2_DOWN] | w[BIT_D_DOWN];
            w[BIT_D2_LEFT] = w[BIT_D2_LEFT] | w[BIT_D_LEFT];
            w[BIT_D2_RGHT] = w[BIT_D2_RGHT] | w[BIT_D_RIGHT];
            w[BIT_D_UP]    = 1'b0;
            w[BIT_D_DOWN]  = 1'b0;
            w[BIT_D_LEFT]  = 1'b0;
            w[BIT_D_RIGHT] = 1'b0;
        end else begin
            // left trigger with Y lands on the alternate bit
            if (lt_on)
                w[w[BIT_Y] ? BIT_VLTALT : BIT_VLTRIG] = 1'b1;
            if (rt_on)
                w[BIT_VRTRIG] = 1'b1;
        end
        r.target_buttons = {slot_hit(w, c.cbutton_select, 0), slot_hit(w, c.cbutton_select, 3),
                            slot_hit(w, c.cbutton_select, 1), slot_hit(w, c.cbutton_select, 2),
                            slot_hit(w, trig, 1), slot_hit(w, trig, 2), slot_hit(w, trig, 0),
                            slot_hit(w, face, 0), slot_hit(w, face, 1), slot_hit(w, face, 2),
                            slot_hit(w, c.dpad_select, 0), slot_hit(w, c.dpad_select, 3),
                            slot_hit(w, c.dpad_select, 1), slot_hit(w, c.dpad_select, 2)};
        combo       = c.exit_combo ? COMBO_SX : COMBO_SAB;
        r.menu_exit = ((w & combo) == combo);
        // axes; the D-pad is read after folding, so both triggers leave it centred
        if (!c.axis_source) begin
            x = p.stick_x - AXIS_CENTRE;
            y = AXIS_CENTRE - p.stick_y;
        end else begin
            x = w[BIT_D_RIGHT] ? AXIS_POS_MAG : (w[BIT_D_LEFT] ? AXIS_NEG_MAG : 8'd0);
            y = w[BIT_D_UP]    ? AXIS_POS_MAG : (w[BIT_D_DOWN] ? AXIS_NEG_MAG : 8'd0);
        end
        // 8-bit negate: -128 stays -128
        if (c.invert_axes[1])
            x = -x;
        if (c.invert_axes[0])
            y = -y;
        r.source_pad  = p.pad_index;
        r.pad_ok      = 1'b1;
        r.x_axis      = x;
        r.y_axis      = y;
        r.mapped_word = w;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic poll_t mk_poll(input logic [1:0] pad, input logic present,
                                      input logic [15:0] buttons, input logic [7:0] sx,
                                      input logic [7:0] sy, input logic [7:0] lt,
                                      input logic [7:0] rt);
        return {pad, present, buttons, sx, sy, lt, rt};
    endfunction

    function automatic result_t mk_res(input logic [1:0] pad, input logic ok,
                                       input logic [13:0] tgt, input logic [7:0] x,
                                       input logic [7:0] y, input logic ex,
                                       input logic [26:0] w);
        return {pad, ok, tgt, x, y, ex, w};
    endfunction

    task automatic add_probe(input poll_t p, input bit pin, input result_t r);
        probe_row_t row;
        row.poll   = p;
        row.pinned = pin;
        row.res    = r;
        probe_rows.push_back(row);
    endtask

    // per-word wait: mostly a uniform random gap, with occasional runs of no waiting
    function automatic int draw_gap(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 4);
    endfunction

    function automatic logic [4:0] rand_index();
        if ($urandom_range(0, 3) != 0)
            return 5'($urandom_range(1, 19));
        return 5'($urandom_range(0, 31));
    endfunction

    function automatic cfg_t random_setting();
        cfg_t c;
        int   k;
        for (k = 0; k < 4; k++) begin
            c.dpad_select[5*k +: 5]    = rand_index();
            c.cbutton_select[5*k +: 5] = rand_index();
        end
        for (k = 0; k < 3; k++) begin
            c.face_select[5*k +: 5]    = rand_index();
            c.trigger_select[5*k +: 5] = rand_index();
        end
        c.exit_combo        = 1'($urandom);
        c.axis_source       = 1'($urandom);
        c.invert_axes       = 2'($urandom);
        c.trigger_threshold = 8'($urandom);
        return c;
    endfunction

    // stick values lean towards the centre and wrap points
    function automatic logic [7:0] pick_axis();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return AXIS_CENTRE;
            3:       return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    // trigger values lean towards the threshold edge
    function automatic logic [7:0] pick_trigger(input logic [7:0] thr);
        case ($urandom_range(0, 5))
            0:       return thr;
            1:       return thr - 8'd1;
            2:       return thr + 8'd1;
            3:       return 8'hFF;
            4:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic poll_t random_poll(input logic [7:0] thr);
        poll_t p;
        p.pad_index   = 2'($urandom);
        p.pad_present = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 3))
            0:       p.raw_buttons = 16'($urandom);
            1:       p.raw_buttons = 16'($urandom) & 16'($urandom);
            // exit combos with a little noise on top
            2:       p.raw_buttons = ($urandom_range(0, 1) ? COMBO_SX[15:0] : COMBO_SAB[15:0])
                                     | (16'($urandom) & 16'($urandom) & 16'($urandom));
            // D-pad and Y only, for the fold and the D-pad axes
            default: p.raw_buttons = 16'($urandom) & 16'h02F0;
        endcase
        p.stick_x       = pick_axis();
        p.stick_y       = pick_axis();
        p.left_trigger  = pick_trigger(thr);
        p.right_trigger = pick_trigger(thr);
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // entered and left at a falling edge
    task automatic send_poll(input poll_t p, input bit pin, input result_t r);
        int gap;
        gap = draw_gap(src_calm);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        pinned_on  = pin;
        pinned_res = r;
        s_poll    <= p;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
    endtask

    task automatic load_setting(input cfg_t c);
        shadow_cfg = c;
        write_reg(REG_DPAD_SELECT, c.dpad_select);
        write_reg(REG_FACE_SELECT, {5'd0, c.face_select});
        write_reg(REG_TRIGGER_SELECT, {5'd0, c.trigger_select});
        write_reg(REG_CBUTTON_SELECT, c.cbutton_select);
        write_reg(REG_EXIT_COMBO, {19'd0, c.exit_combo});
        write_reg(REG_AXIS_SOURCE, {19'd0, c.axis_source});
        write_reg(REG_INVERT_AXES, {18'd0, c.invert_axes});
        write_reg(REG_TRIG_THRESHOLD, {12'd0, c.trigger_threshold});
        cfg_we <= 1'b0;
    endtask

    // stop sending and let every outstanding word drain out
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_maps.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // result side: random stalls per word
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            gap = draw_gap(snk_calm);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            @(negedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Scoreboard
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [26:0] want,
                                        input logic [26:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s expected %0h, got %0h", $realtime, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : scoreboard
        result_t want;
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_maps.push_back(pinned_on ? pinned_res : remap_poll(s_poll, shadow_cfg));
            if (m_valid && m_ready) begin
                if (pending_maps.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result word with none pending, pad %0d",
                                 $realtime, m_source_pad);
                end else begin
                    want = pending_maps.pop_front();
                    // axes compared as raw 8-bit patterns, zero-extended
                    check_field("source_pad", 27'(want.source_pad), 27'(m_source_pad));
                    check_field("pad_ok", 27'(want.pad_ok), 27'(m_pad_ok));
                    check_field("target_buttons", 27'(want.target_buttons),
                                27'(m_target_buttons));
                    check_field("x_axis", 27'(want.x_axis), 27'($unsigned(m_x_axis)));
                    check_field("y_axis", 27'(want.y_axis), 27'($unsigned(m_y_axis)));
                    check_field("menu_exit", 27'(want.menu_exit), 27'(m_menu_exit));
                    check_field("mapped_word", want.mapped_word, m_mapped_word);
                end
            end
        end
    end

    // watchdog: too long with no word moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int   phase;
        cfg_t setting;
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_addr    = '0;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_poll      = '0;
        pinned_on   = 1'b0;
        pinned_res  = '0;
        mismatches  = 0;
        idle_cycles = 0;
        src_calm    = 0;
        snk_calm    = 0;
        shadow_cfg  = DEFAULT_SETTING;

        // directed polls under the reset setting
        // missing pad: all zero whatever the inputs
        add_probe(mk_poll(2'd1, 1'b0, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF), 1'b1,
                  mk_res(2'd0, 1'b0, 14'h0000, 8'h00, 8'h00, 1'b0, 27'h0000000));
        add_probe(mk_poll(2'd3, 1'b1, 16'h0000, 8'h80, 8'h80, 8'h00, 8'h00), 1'b1,
                  mk_res(2'd3, 1'b1, 14'h0000, 8'h00, 8'h00, 1'b0, 27'h0000000));
        // stick extremes, wrap of the centred value
        add_probe(mk_poll(2'd0, 1'b1, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00), 1'b1,
                  mk_res(2'd0, 1'b1, 14'h0000, 8'h80, 8'h80, 1'b0, 27'h0000000));
        add_probe(mk_poll(2'd2, 1'b1, 16'h0000, 8'hFF, 8'hFF, 8'h00, 8'h00), 1'b1,
                  mk_res(2'd2, 1'b1, 14'h0000, 8'h7F, 8'h81, 1'b0, 27'h0000000));
        // every button held
        add_probe(mk_poll(2'd1, 1'b1, 16'hFFFF, 8'h80, 8'h80, 8'h00, 8'h00), 1'b1,
                  mk_res(2'd1, 1'b1, 14'h3C7F, 8'h00, 8'h00, 1'b1, 27'h000FFFF));
        // both triggers: D-pad moved onto the second D-pad
        add_probe(mk_poll(2'd0, 1'b1, 16'h00F0, 8'h80, 8'h80, 8'hFF, 8'hFF), 1'b1,
                  mk_res(2'd0, 1'b1, 14'h3C00, 8'h00, 8'h00, 1'b0, 27'h000F000));
        // left trigger exactly at threshold, right just under
        add_probe(mk_poll(2'd0, 1'b1, 16'h0000, 8'h80, 8'h80, 8'd48, 8'd47), 1'b1,
                  mk_res(2'd0, 1'b1, 14'h0080, 8'h00, 8'h00, 1'b0, 27'h1000000));
        // left trigger with Y held
        add_probe(mk_poll(2'd0, 1'b1, 16'h0200, 8'h80, 8'h80, 8'd48, 8'h00), 1'b1,
                  mk_res(2'd0, 1'b1, 14'h0200, 8'h00, 8'h00, 1'b0, 27'h4000200));
        add_probe(mk_poll(2'd3, 1'b1, 16'h0000, 8'h80, 8'h80, 8'h00, 8'hFF), 1'b1,
                  mk_res(2'd3, 1'b1, 14'h0100, 8'h00, 8'h00, 1'b0, 27'h2000000));
        add_probe(mk_poll(2'd0, 1'b1, 16'h0000, 8'h80, 8'h80, 8'd47, 8'd47), 1'b1,
                  mk_res(2'd0, 1'b1, 14'h0000, 8'h00, 8'h00, 1'b0, 27'h0000000));
        // the rest go through the predictor
        add_probe(mk_poll(2'd1, 1'b1, 16'h000E, 8'h40, 8'hC0, 8'h10, 8'h20), 1'b0, '0);
        add_probe(mk_poll(2'd2, 1'b1, 16'h0408, 8'h81, 8'h7F, 8'h00, 8'h00), 1'b0, '0);
        add_probe(mk_poll(2'd3, 1'b1, 16'h0050, 8'h01, 8'hFE, 8'hFF, 8'hFF), 1'b0, '0);
        add_probe(mk_poll(2'd0, 1'b1, 16'h00A0, 8'hFE, 8'h01, 8'h00, 8'h00), 1'b0, '0);
        add_probe(mk_poll(2'd1, 1'b1, 16'hFFFF, 8'h80, 8'h80, 8'hFF, 8'hFF), 1'b0, '0);
        add_probe(mk_poll(2'd2, 1'b1, 16'h0270, 8'h55, 8'hAA, 8'd48, 8'd48), 1'b0, '0);
        add_probe(mk_poll(2'd3, 1'b1, 16'hAAAA, 8'hAA, 8'h55, 8'hFF, 8'h00), 1'b0, '0);
        add_probe(mk_poll(2'd0, 1'b1, 16'h5555, 8'h33, 8'hCC, 8'h00, 8'hFF), 1'b0, '0);

        // synchronous reset
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        foreach (probe_rows[i])
            send_poll(probe_rows[i].poll, probe_rows[i].pinned, probe_rows[i].res);

        // random polls, one register setting per phase
        for (phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                wait_idle();
                case (phase)
                    1:       setting = '0;
                    2:       setting = '1;
                    3: begin
                        setting             = DEFAULT_SETTING;
                        setting.axis_source = 1'b1;
                        setting.invert_axes = 2'b11;
                    end
                    default: setting = random_setting();
                endcase
                load_setting(setting);
            end
            repeat (PHASE_POLLS) send_poll(random_poll(shadow_cfg.trigger_threshold), 1'b0, '0);
        end

        wait_idle();
        repeat (4) @(posedge aclk);
        if (mismatches == 0 && pending_maps.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
